// ===== src/fsge_pkg.sv =====
package fsge_pkg;

	// Grid and cell geometry.
	localparam int GRID_CELLS    = 16;
	localparam int MAX_CELL_SIZE = 64;
	localparam int CELL_W        = $clog2(GRID_CELLS);
	localparam int OFF_W         = $clog2(MAX_CELL_SIZE);

	// Register file addressing.
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_KEY_COLOUR  = 2'd0;
	localparam logic [1:0] REG_CELL_WIDTH  = 2'd1;
	localparam logic [1:0] REG_CELL_HEIGHT = 2'd2;
	localparam logic [1:0] REG_SHEET_WIDTH = 2'd3;

	// Register reset values.
	localparam logic [31:0] KEY_COLOUR_RST  = 32'h0000_FFFF;
	localparam logic [6:0]  CELL_WIDTH_RST  = 7'd8;
	localparam logic [6:0]  CELL_HEIGHT_RST = 7'd8;
	localparam logic [12:0] SHEET_WIDTH_RST = 13'd128;

	// Sheet width limits.
	localparam logic [12:0] SHEET_WIDTH_MIN = 13'd16;
	localparam logic [12:0] SHEET_WIDTH_MAX = 13'd4096;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic        frame_start;
	} pixel_t;

	typedef struct packed {
		logic [7:0] glyph_code;
		logic [9:0] glyph_x;
		logic [9:0] glyph_y;
		logic [6:0] glyph_w;
		logic [6:0] glyph_h;
		logic       last_glyph;
	} glyph_t;

	// Effective settings, already clamped to their legal ranges.
	typedef struct packed {
		logic [31:0] key_colour;
		logic [6:0]  cell_width;
		logic [6:0]  cell_height;
		logic [12:0] sheet_width;
	} cfg_t;

endpackage

// ===== src/fsge_cfg.sv =====
module fsge_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fsge_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output fsge_pkg::cfg_t                cfg
);

	logic [31:0] key_colour_q;
	logic [6:0]  cell_width_q;
	logic [6:0]  cell_height_q;
	logic [12:0] sheet_width_q;
	logic [1:0]  reg_index;
	logic        wr_en;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign wr_en     = psel && penable && pwrite;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_colour_q  <= fsge_pkg::KEY_COLOUR_RST;
			cell_width_q  <= fsge_pkg::CELL_WIDTH_RST;
			cell_height_q <= fsge_pkg::CELL_HEIGHT_RST;
			sheet_width_q <= fsge_pkg::SHEET_WIDTH_RST;
		end else if (wr_en) begin
			case (reg_index)
				fsge_pkg::REG_KEY_COLOUR:  key_colour_q  <= pwdata;
				fsge_pkg::REG_CELL_WIDTH:  cell_width_q  <= pwdata[6:0];
				fsge_pkg::REG_CELL_HEIGHT: cell_height_q <= pwdata[6:0];
				fsge_pkg::REG_SHEET_WIDTH: sheet_width_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Read back the raw register contents.
	always_comb begin
		case (reg_index)
			fsge_pkg::REG_KEY_COLOUR:  prdata = key_colour_q;
			fsge_pkg::REG_CELL_WIDTH:  prdata = {25'd0, cell_width_q};
			fsge_pkg::REG_CELL_HEIGHT: prdata = {25'd0, cell_height_q};
			fsge_pkg::REG_SHEET_WIDTH: prdata = {19'd0, sheet_width_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// Clamp the sizes to what the scanner supports.
	always_comb begin
		cfg.key_colour = key_colour_q;

		if (cell_width_q == 7'd0)
			cfg.cell_width = 7'd1;
		else if (cell_width_q > 7'(fsge_pkg::MAX_CELL_SIZE))
			cfg.cell_width = 7'(fsge_pkg::MAX_CELL_SIZE);
		else
			cfg.cell_width = cell_width_q;

		if (cell_height_q == 7'd0)
			cfg.cell_height = 7'd1;
		else if (cell_height_q > 7'(fsge_pkg::MAX_CELL_SIZE))
			cfg.cell_height = 7'(fsge_pkg::MAX_CELL_SIZE);
		else
			cfg.cell_height = cell_height_q;

		if (sheet_width_q < fsge_pkg::SHEET_WIDTH_MIN)
			cfg.sheet_width = fsge_pkg::SHEET_WIDTH_MIN;
		else if (sheet_width_q > fsge_pkg::SHEET_WIDTH_MAX)
			cfg.sheet_width = fsge_pkg::SHEET_WIDTH_MAX;
		else
			cfg.sheet_width = sheet_width_q;
	end

endmodule

// ===== src/font_sheet_glyph_extent_scanner.sv =====
// Channel  | Direction | Handshake             | Request
// ---------+-----------+-----------------------+------------------------------
// in       | input     | in_valid / in_stall   | pixel_t: one sheet pixel
// out      | output    | out_valid / out_stall | glyph_t: one glyph extent
// config   | input     | APB psel/penable      | key, cell and sheet sizes
//
// One pixel is taken every cycle while in_stall is low; a glyph result is
// registered after the bottom-right pixel of its cell is accepted (the pixel
// waits in the input register, then loads the result register). The per-cell
// ink table is read and updated combinationally and written as the pixel
// advances. Reset puts all counters at the top-left of the sheet and clears the
// ink flags; the extents are not reset. A stalled result holds its register; the
// input register still fills behind it, and only then does in_stall rise.
module font_sheet_glyph_extent_scanner (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  fsge_pkg::pixel_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output fsge_pkg::glyph_t             out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fsge_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int GC    = fsge_pkg::GRID_CELLS;
	localparam int OFF_W = fsge_pkg::OFF_W;
	localparam int IDX_W = fsge_pkg::CELL_W + 1;

	fsge_pkg::cfg_t cfg;

	fsge_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register.
	logic             pix_valid_s1;
	fsge_pkg::pixel_t pix_s1;

	// Position counters.
	logic [11:0]      col_q;
	logic [OFF_W-1:0] cell_off_q;
	logic [IDX_W-1:0] cell_idx_q;
	logic [OFF_W-1:0] band_row_q;
	logic [IDX_W-1:0] band_idx_q;

	// Per-cell ink extents of the current band.
	logic [OFF_W-1:0] left_q  [GC];
	logic [OFF_W-1:0] right_q [GC];
	logic [GC-1:0]    seen_q;

	// Result register.
	logic             out_valid_q;
	fsge_pkg::glyph_t out_q;

	logic out_free;
	logic advance;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = pix_valid_s1 && out_free;
	assign in_stall  = pix_valid_s1 && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Working values for the pixel in the input register.
	logic                       fs;
	logic [11:0]                cur_col;
	logic [OFF_W-1:0]           cur_off;
	logic [IDX_W-1:0]           cur_cell;
	logic [OFF_W-1:0]           cur_brow;
	logic [IDX_W-1:0]           cur_band;
	logic [fsge_pkg::CELL_W-1:0] c;
	logic                       in_grid;
	logic                       ink;
	logic                       ent_seen;
	logic [OFF_W-1:0]           ent_left;
	logic [OFF_W-1:0]           ent_right;
	logic                       new_seen;
	logic [OFF_W-1:0]           new_left;
	logic [OFF_W-1:0]           new_right;
	logic                       emit;
	logic                       row_end;
	logic                       band_end;
	logic [6:0]                 brow_inc;
	logic [6:0]                 off_inc;
	logic [IDX_W-1:0]           col_n_cell;
	logic [10:0]                x_base;
	logic [10:0]                y_base;
	logic [6:0]                 ink_w;
	fsge_pkg::glyph_t           glyph;

	always_comb begin
		// A frame start puts the position back to the top-left first.
		fs       = pix_s1.frame_start;
		cur_col  = fs ? 12'd0 : col_q;
		cur_off  = fs ? '0 : cell_off_q;
		cur_cell = fs ? '0 : cell_idx_q;
		cur_brow = fs ? '0 : band_row_q;
		cur_band = fs ? '0 : band_idx_q;
		c        = cur_cell[fsge_pkg::CELL_W-1:0];
		in_grid  = !cur_cell[IDX_W-1] && !cur_band[IDX_W-1];

		ent_seen  = fs ? 1'b0 : seen_q[c];
		ent_left  = left_q[c];
		ent_right = right_q[c];

		// Widen the extents with this pixel if it carries ink.
		ink       = pix_s1.pixel_value != cfg.key_colour;
		new_seen  = ent_seen;
		new_left  = ent_left;
		new_right = ent_right;
		if (ink) begin
			new_seen = 1'b1;
			if (!ent_seen) begin
				new_left  = cur_off;
				new_right = cur_off;
			end else begin
				if (cur_off < ent_left)
					new_left = cur_off;
				if (cur_off > ent_right)
					new_right = cur_off;
			end
		end

		// Bottom-right pixel of a cell closes the glyph.
		emit = in_grid
			&& (cur_off == OFF_W'(cfg.cell_width - 7'd1))
			&& (cur_brow == OFF_W'(cfg.cell_height - 7'd1));

		x_base = 11'(c) * 11'(cfg.cell_width);
		y_base = 11'(cur_band[fsge_pkg::CELL_W-1:0]) * 11'(cfg.cell_height);
		ink_w  = 7'(new_right) - 7'(new_left) + 7'd1;

		glyph.glyph_code = {cur_band[fsge_pkg::CELL_W-1:0], c};
		glyph.glyph_x    = new_seen ? 10'(x_base + 11'(new_left)) : 10'(x_base);
		glyph.glyph_y    = 10'(y_base);
		glyph.glyph_w    = new_seen ? ink_w : cfg.cell_width;
		glyph.glyph_h    = cfg.cell_height;
		glyph.last_glyph = glyph.glyph_code == 8'hFF;

		// Position step.
		row_end    = (13'(cur_col) + 13'd1) >= cfg.sheet_width;
		brow_inc   = 7'(cur_brow) + 7'd1;
		off_inc    = 7'(cur_off) + 7'd1;
		band_end   = row_end && (brow_inc >= cfg.cell_height);
		col_n_cell = cur_cell + IDX_W'(1);
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			pix_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			pix_s1 <= in_data;
		end
	end

	// Position counters advance once per processed pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			cell_off_q <= '0;
			cell_idx_q <= '0;
			band_row_q <= '0;
			band_idx_q <= '0;
		end else if (advance) begin
			if (row_end) begin
				col_q      <= '0;
				cell_off_q <= '0;
				cell_idx_q <= '0;
				if (band_end) begin
					band_row_q <= '0;
					band_idx_q <= cur_band[IDX_W-1] ? cur_band : cur_band + IDX_W'(1);
				end else begin
					band_row_q <= OFF_W'(brow_inc);
					band_idx_q <= cur_band;
				end
			end else begin
				col_q      <= cur_col + 12'd1;
				band_row_q <= cur_brow;
				band_idx_q <= cur_band;
				if (!cur_cell[IDX_W-1]) begin
					if (off_inc >= cfg.cell_width) begin
						cell_off_q <= '0;
						cell_idx_q <= col_n_cell;
					end else begin
						cell_off_q <= OFF_W'(off_inc);
						cell_idx_q <= cur_cell;
					end
				end else begin
					cell_off_q <= cur_off;
					cell_idx_q <= cur_cell;
				end
			end
		end
	end

	// Ink flags: cleared at a band end or a frame start, set on this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < GC; i++) begin
				if (band_end)
					seen_q[i] <= 1'b0;
				else if (in_grid && (c == fsge_pkg::CELL_W'(i)))
					seen_q[i] <= new_seen;
				else if (fs)
					seen_q[i] <= 1'b0;
			end
		end
	end

	// Extents are only meaningful while the cell's flag is set.
	always_ff @(posedge clk) begin
		if (advance && in_grid && ink) begin
			left_q[c]  <= new_left;
			right_q[c] <= new_right;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= glyph;
		end
	end

endmodule
